// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define SLAC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// cond must never be seen outside reset
`define SLAC_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

// ===== design/slac_pkg.sv =====
`default_nettype none

package slac_pkg;

  localparam int COORD_BITS = 12;
  localparam int SUM_BITS   = COORD_BITS + 1;

  localparam int FIFO_DEPTH_DEF = 4;

  // APB: two 32-bit registers at byte addresses 0 and 4
  localparam int APB_ADDR_W = 3;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RST  = COORD_BITS'(1920);
  localparam logic [COORD_BITS-1:0] FRAME_HEIGHT_RST = COORD_BITS'(1080);

  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_PIXEL  = 2'd1,
    ACT_EOF    = 2'd2
  } action_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_CLIP  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]            action;
    logic [COORD_BITS-1:0] layer_x;
    logic [COORD_BITS-1:0] layer_y;
    logic [COORD_BITS-1:0] layer_w;
    logic [COORD_BITS-1:0] layer_h;
    logic [31:0]           layer_color;
    logic [7:0]            coverage;
    logic [31:0]           old_pixel;
  } in_item_t;

  typedef struct packed {
    kind_e                 result_kind;
    logic [SUM_BITS-1:0]   pixel_x;
    logic [SUM_BITS-1:0]   pixel_y;
    logic [31:0]           new_pixel;
    logic [COORD_BITS-1:0] clip_min_x;
    logic [COORD_BITS-1:0] clip_min_y;
    logic [SUM_BITS-1:0]   clip_max_x;
    logic [SUM_BITS-1:0]   clip_max_y;
  } out_item_t;

  // res.new_pixel carries the old destination pixel until the blend
  typedef struct packed {
    out_item_t   res;
    logic [31:0] color;
    logic [7:0]  coverage;
  } job_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] frame_width;
    logic [COORD_BITS-1:0] frame_height;
  } cfg_t;

  // floor(x/255), exact for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== design/slac_fifo.sv =====
`default_nettype none

module slac_fifo #(
  parameter int DEPTH = slac_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire slac_pkg::job_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output slac_pkg::job_t     pop_data_o
);

  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  slac_pkg::job_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SLAC_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o, "request pushed into full queue")
  `SLAC_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== design/slac_front.sv =====
`default_nettype none

module slac_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire slac_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire slac_pkg::in_item_t in_item_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output slac_pkg::job_t          push_job_o
);

  `include "assert_macros.svh"

  localparam int CW = slac_pkg::COORD_BITS;
  localparam int SW = slac_pkg::SUM_BITS;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0] cur_w_q, cur_w_d, cur_h_q, cur_h_d;
  logic [31:0]   cur_color_q, cur_color_d;
  logic [CW-1:0] min_x_q, min_x_d, min_y_q, min_y_d;
  logic [SW-1:0] max_x_q, max_x_d, max_y_q, max_y_d;
  logic          any_q, any_d;
  logic          accept;
  logic [SW-1:0] end_x, end_y;
  logic [CW-1:0] col_inc;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign end_x      = {1'b0, in_item_i.layer_x} + {1'b0, in_item_i.layer_w};
  assign end_y      = {1'b0, in_item_i.layer_y} + {1'b0, in_item_i.layer_h};
  // col_q < cur_w_q whenever a pixel is taken, so no wrap here
  assign col_inc    = col_q + CW'(1);

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    cur_w_d     = cur_w_q;
    cur_h_d     = cur_h_q;
    cur_color_d = cur_color_q;
    min_x_d     = min_x_q;
    min_y_d     = min_y_q;
    max_x_d     = max_x_q;
    max_y_d     = max_y_q;
    any_d       = any_q;
    push_o      = 1'b0;
    push_job_o  = '0;
    if (accept) begin
      case (in_item_i.action)
        slac_pkg::ACT_HEADER: begin
          cur_x_d     = in_item_i.layer_x;
          cur_y_d     = in_item_i.layer_y;
          cur_w_d     = in_item_i.layer_w;
          cur_h_d     = in_item_i.layer_h;
          cur_color_d = in_item_i.layer_color;
          col_d       = '0;
          row_d       = '0;
          if (in_item_i.layer_x < min_x_q) min_x_d = in_item_i.layer_x;
          if (in_item_i.layer_y < min_y_q) min_y_d = in_item_i.layer_y;
          if (end_x > max_x_q) max_x_d = end_x;
          if (end_y > max_y_q) max_y_d = end_y;
          any_d = 1'b1;
        end
        slac_pkg::ACT_PIXEL: begin
          if (cur_w_q != '0 && row_q < cur_h_q) begin
            push_o                     = 1'b1;
            push_job_o.res.result_kind = slac_pkg::KIND_PIXEL;
            push_job_o.res.pixel_x     = {1'b0, cur_x_q} + {1'b0, col_q};
            push_job_o.res.pixel_y     = {1'b0, cur_y_q} + {1'b0, row_q};
            push_job_o.res.new_pixel   = in_item_i.old_pixel;
            push_job_o.color           = cur_color_q;
            push_job_o.coverage        = in_item_i.coverage;
            if (col_inc >= cur_w_q) begin
              col_d = '0;
              row_d = row_q + CW'(1);
            end else begin
              col_d = col_inc;
            end
          end
        end
        slac_pkg::ACT_EOF: begin
          if (any_q) begin
            push_o                     = 1'b1;
            push_job_o.res.result_kind = slac_pkg::KIND_CLIP;
            push_job_o.res.clip_min_x  = min_x_q;
            push_job_o.res.clip_min_y  = min_y_q;
            push_job_o.res.clip_max_x  = max_x_q;
            push_job_o.res.clip_max_y  = max_y_q;
          end
          min_x_d = cfg_i.frame_width;
          min_y_d = cfg_i.frame_height;
          max_x_d = '0;
          max_y_d = '0;
          any_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_w_q     <= '0;
      cur_h_q     <= '0;
      cur_color_q <= '0;
      min_x_q     <= slac_pkg::FRAME_WIDTH_RST;
      min_y_q     <= slac_pkg::FRAME_HEIGHT_RST;
      max_x_q     <= '0;
      max_y_q     <= '0;
      any_q       <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cur_w_q     <= cur_w_d;
      cur_h_q     <= cur_h_d;
      cur_color_q <= cur_color_d;
      min_x_q     <= min_x_d;
      min_y_q     <= min_y_d;
      max_x_q     <= max_x_d;
      max_y_q     <= max_y_d;
      any_q       <= any_d;
    end
  end

  `SLAC_ASSERT(a_col_in_layer, clk_i, rst_ni, cur_w_q != '0 |-> col_q < cur_w_q, "column counter left the layer")
  `SLAC_ASSERT(a_clip_needs_layer, clk_i, rst_ni, push_o && push_job_o.res.result_kind == slac_pkg::KIND_CLIP |-> any_q, "clip box sent without a layer")

endmodule

`default_nettype wire

// ===== design/slac_back.sv =====
`default_nettype none

module slac_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire slac_pkg::job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output slac_pkg::out_item_t out_item_o
);

  `include "assert_macros.svh"

  logic en;
  logic v0_q, v1_q, v2_q, out_valid_q;
  slac_pkg::job_t job0_q, job1_q, job2_q;
  slac_pkg::out_item_t out_q, out_d;
  logic [15:0] prod_q, prod_d;
  logic [7:0]  an_q;
  logic [7:0]  inv_an;
  logic [15:0] alpha_q, alpha_d;
  logic [15:0] sum_q [3];
  logic [15:0] sum_d [3];
  logic [7:0]  mix [3];

  // whole pipeline moves as one; it freezes only while the output is held
  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign prod_d = 16'(8'hFF - job_i.color[7:0]) * 16'(job_i.coverage);
  assign inv_an = 8'hFF - an_q;
  assign alpha_d = 16'(8'hFF - job1_q.res.new_pixel[31:24]) * 16'(inv_an);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = 16'(job1_q.res.new_pixel[8*(2-i) +: 8]) * 16'(inv_an)
               + 16'(job1_q.color[8*(3-i) +: 8]) * 16'(an_q);
      mix[i]   = slac_pkg::div255(sum_q[i]);
    end
    out_d = job2_q.res;
    if (job2_q.res.result_kind == slac_pkg::KIND_PIXEL) begin
      out_d.new_pixel = {8'hFF - slac_pkg::div255(alpha_q), mix[0], mix[1], mix[2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= job_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      job0_q  <= job_i;
      prod_q  <= prod_d;
      job1_q  <= job0_q;
      an_q    <= slac_pkg::div255(prod_q);
      job2_q  <= job1_q;
      alpha_q <= alpha_d;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_d[i];
      end
      out_q   <= out_d;
    end
  end

  `SLAC_ASSERT(a_stall_holds, clk_i, rst_ni, v2_q && !en |=> v2_q, "pipeline dropped a request while stalled")
  `SLAC_ASSERT(a_pixel_no_clip, clk_i, rst_ni, out_valid_q && out_q.result_kind == slac_pkg::KIND_PIXEL |-> out_q.clip_max_x == '0 && out_q.clip_max_y == '0, "pixel result carries clip data")

endmodule

`default_nettype wire

// ===== design/subtitle_layer_alpha_compositor_top.sv =====
// Subtitle layer compositor. Items enter on the in_* channel: a layer header sets
// origin, size and RGBA color and widens the frame's clip box; each coverage pixel
// is blended over its old ARGB pixel and leaves on the out_* channel with its
// destination coordinate (row-major inside the layer; extra pixels are dropped);
// end of frame sends the clip box if any layer was seen and restarts it from the
// frame_width / frame_height registers, which take effect at the next end of frame.
// One item is accepted per clock while the four-entry request queue has room.
// A result passes through the queue, three blend stages (opacity product, opacity
// scale, channel products) and the output register. Back pressure on the output
// freezes the blend pipeline; the queue then fills.
`default_nettype none

module subtitle_layer_alpha_compositor_top #(
  parameter int FIFO_DEPTH = slac_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [slac_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire slac_pkg::in_item_t                in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output slac_pkg::out_item_t                    out_item_o
);

  localparam int CW = slac_pkg::COORD_BITS;

  slac_pkg::cfg_t cfg_q, cfg_d;
  logic           apb_wr;
  logic           reg_sel;
  logic           q_full, q_push, q_valid, q_pop;
  slac_pkg::job_t q_in, q_out;

  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[slac_pkg::APB_ADDR_W-1];
  assign prdata  = (reg_sel == slac_pkg::REG_FRAME_HEIGHT)
                 ? {(32-CW)'(0), cfg_q.frame_height}
                 : {(32-CW)'(0), cfg_q.frame_width};

  always_comb begin
    cfg_d = cfg_q;
    if (apb_wr) begin
      case (reg_sel)
        slac_pkg::REG_FRAME_WIDTH:  cfg_d.frame_width  = pwdata[CW-1:0];
        slac_pkg::REG_FRAME_HEIGHT: cfg_d.frame_height = pwdata[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= slac_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height <= slac_pkg::FRAME_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  slac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .push_job_o (q_in)
  );

  slac_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  slac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_subtitle_layer_alpha_compositor_top.sv =====
`timescale 1ns / 1ps

module tb_subtitle_layer_alpha_compositor_top;
  import slac_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 10;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 150;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    in_item_t  item;
    logic      typed;
    logic      has_res;
    out_item_t res;
  } req_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;

  subtitle_layer_alpha_compositor_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // compositor state as the testbench sees it
  logic [COORD_BITS-1:0] reg_width  = FRAME_WIDTH_RST;
  logic [COORD_BITS-1:0] reg_height = FRAME_HEIGHT_RST;
  logic [COORD_BITS-1:0] pos_col    = '0;
  logic [COORD_BITS-1:0] pos_row    = '0;
  logic [COORD_BITS-1:0] lyr_x      = '0;
  logic [COORD_BITS-1:0] lyr_y      = '0;
  logic [COORD_BITS-1:0] lyr_w      = '0;
  logic [COORD_BITS-1:0] lyr_h      = '0;
  logic [31:0]           lyr_color  = '0;
  logic [COORD_BITS-1:0] box_x0     = FRAME_WIDTH_RST;
  logic [COORD_BITS-1:0] box_y0     = FRAME_HEIGHT_RST;
  logic [SUM_BITS-1:0]   box_x1     = '0;
  logic [SUM_BITS-1:0]   box_y1     = '0;
  logic                  box_seen   = 1'b0;

  req_row_t  offered_rows[$];
  out_item_t pending_results[$];

  int  n_fail    = 0;
  int  n_req     = 0;
  int  n_headers = 0;
  int  n_blended = 0;
  int  n_boxes   = 0;
  int  n_cfg     = 0;
  int  n_hold    = 0;
  int  cycles    = 0;
  int  stall_left = 0;
  bit  steady    = 1'b0;
  bit  hold_out  = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("MISMATCH %s: got 0x%0h want 0x%0h (cycle %0d)", what, got_v, want_v, cycles);
    n_fail++;
  endtask

  function automatic logic [7:0] mix_channel(input int unsigned old_c, input int unsigned new_c,
                                             input int unsigned an);
    return 8'((old_c * (255 - an) + new_c * an) / 255);
  endfunction

  function automatic logic [31:0] blend_pixel(input logic [31:0] color, input logic [7:0] cov,
                                              input logic [31:0] old);
    int unsigned ta, an, oa, na;
    ta = color[7:0];
    an = (255 - ta) * int'(cov) / 255;
    oa = old[31:24];
    na = 255 - (255 - oa) * (255 - an) / 255;
    return {8'(na), mix_channel(old[23:16], color[31:24], an),
            mix_channel(old[15:8], color[23:16], an), mix_channel(old[7:0], color[15:8], an)};
  endfunction

  task automatic composite_predict(input in_item_t it, output logic has_res,
                                   output out_item_t res);
    logic [SUM_BITS-1:0] sx, sy;
    res = '0;
    has_res = 1'b0;
    case (it.action)
      ACT_HEADER: begin
        lyr_x = it.layer_x;
        lyr_y = it.layer_y;
        lyr_w = it.layer_w;
        lyr_h = it.layer_h;
        lyr_color = it.layer_color;
        pos_col = '0;
        pos_row = '0;
        sx = {1'b0, it.layer_x} + {1'b0, it.layer_w};
        sy = {1'b0, it.layer_y} + {1'b0, it.layer_h};
        if (it.layer_x < box_x0) box_x0 = it.layer_x;
        if (sx > box_x1) box_x1 = sx;
        if (it.layer_y < box_y0) box_y0 = it.layer_y;
        if (sy > box_y1) box_y1 = sy;
        box_seen = 1'b1;
        n_headers++;
      end
      ACT_PIXEL: begin
        if (lyr_w != '0 && pos_row < lyr_h) begin
          has_res = 1'b1;
          res.result_kind = KIND_PIXEL;
          res.pixel_x = {1'b0, lyr_x} + {1'b0, pos_col};
          res.pixel_y = {1'b0, lyr_y} + {1'b0, pos_row};
          res.new_pixel = blend_pixel(lyr_color, it.coverage, it.old_pixel);
          pos_col = pos_col + 1'b1;
          if (pos_col >= lyr_w) begin
            pos_col = '0;
            pos_row = pos_row + 1'b1;
          end
          n_blended++;
        end
      end
      ACT_EOF: begin
        if (box_seen) begin
          has_res = 1'b1;
          res.result_kind = KIND_CLIP;
          res.clip_min_x = box_x0;
          res.clip_min_y = box_y0;
          res.clip_max_x = box_x1;
          res.clip_max_y = box_y1;
          n_boxes++;
        end
        box_x0 = reg_width;
        box_y0 = reg_height;
        box_x1 = '0;
        box_y1 = '0;
        box_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic accept_request(input in_item_t it);
    req_row_t  row;
    logic      has_res;
    out_item_t res;
    if (offered_rows.size() == 0) begin
      report_mismatch("request accepted that was never offered", 32'(it.action), '0);
      return;
    end
    row = offered_rows.pop_front();
    composite_predict(it, has_res, res);
    if (row.typed) begin
      has_res = row.has_res;
      res = row.res;
    end
    if (has_res) pending_results.push_back(res);
    n_req++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, new_pixel", got.new_pixel, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.result_kind !== want.result_kind)
      report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
    if (got.pixel_x !== want.pixel_x) report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
    if (got.pixel_y !== want.pixel_y) report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
    if (got.new_pixel !== want.new_pixel)
      report_mismatch("new_pixel", got.new_pixel, want.new_pixel);
    if (got.clip_min_x !== want.clip_min_x)
      report_mismatch("clip_min_x", got.clip_min_x, want.clip_min_x);
    if (got.clip_min_y !== want.clip_min_y)
      report_mismatch("clip_min_y", got.clip_min_y, want.clip_min_y);
    if (got.clip_max_x !== want.clip_max_x)
      report_mismatch("clip_max_x", got.clip_max_x, want.clip_max_x);
    if (got.clip_max_y !== want.clip_max_y)
      report_mismatch("clip_max_y", got.clip_max_y, want.clip_max_y);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) accept_request(in_item_i);
      if (out_valid_o && out_ready_i) check_result(out_item_o);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk_item(input logic [1:0] act, input int x, input int y,
                                       input int w, input int h, input logic [31:0] color,
                                       input logic [7:0] cov, input logic [31:0] old);
    in_item_t it;
    it.action = act;
    it.layer_x = COORD_BITS'(x);
    it.layer_y = COORD_BITS'(y);
    it.layer_w = COORD_BITS'(w);
    it.layer_h = COORD_BITS'(h);
    it.layer_color = color;
    it.coverage = cov;
    it.old_pixel = old;
    return it;
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] act);
    return mk_item(act, $urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                   $urandom);
  endfunction

  function automatic req_row_t mk_row(input in_item_t it, input logic typed,
                                      input logic has_res, input out_item_t res);
    req_row_t row;
    row.item = it;
    row.typed = typed;
    row.has_res = has_res;
    row.res = res;
    return row;
  endfunction

  function automatic req_row_t plain_row(input in_item_t it);
    return mk_row(it, 1'b0, 1'b0, '0);
  endfunction

  function automatic out_item_t mk_pix_res(input int x, input int y, input logic [31:0] p);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_PIXEL;
    r.pixel_x = SUM_BITS'(x);
    r.pixel_y = SUM_BITS'(y);
    r.new_pixel = p;
    return r;
  endfunction

  function automatic out_item_t mk_clip_res(input int x0, input int y0, input int x1,
                                            input int y1);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_CLIP;
    r.clip_min_x = COORD_BITS'(x0);
    r.clip_min_y = COORD_BITS'(y0);
    r.clip_max_x = SUM_BITS'(x1);
    r.clip_max_y = SUM_BITS'(y1);
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 80) return COORD_BITS'($urandom_range(1, 6));
    if (r < 92) return COORD_BITS'($urandom);
    return '1;
  endfunction

  // valid stays up across back-to-back requests; only one NBA per edge
  task automatic send_row(input req_row_t row);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_rows.push_back(row);
    in_valid_i <= 1'b1;
    in_item_i <= row.item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (offered_rows.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // APB write, then read back
  task automatic write_frame_reg(input logic idx, input logic [COORD_BITS-1:0] val);
    logic [31:0] word;
    word = $urandom;
    word[COORD_BITS-1:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_FRAME_WIDTH) reg_width = val;
    else reg_height = val;
    n_cfg++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(32 - COORD_BITS){1'b0}}, val})
      report_mismatch("register read back", prdata, 32'(val));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    int        sent, npx, r;
    in_item_t  it;
    sent = 0;
    send_row(plain_row(rand_item(ACT_EOF)));
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        it = rand_item(ACT_HEADER);
        it.layer_x = pick_coord();
        it.layer_y = pick_coord();
        it.layer_w = pick_size();
        it.layer_h = pick_size();
        send_row(plain_row(it));
        sent++;
        npx = int'(it.layer_w) * int'(it.layer_h);
        if (npx > 20) npx = $urandom_range(1, 20);
        // a few items past the layer's end, or cut short
        if ($urandom_range(0, 3) == 0) npx += $urandom_range(1, 2);
        for (int i = 0; i < npx; i++) send_row(plain_row(rand_item(ACT_PIXEL)));
        sent += npx;
      end else if (r < 87) begin
        send_row(plain_row(rand_item(ACT_EOF)));
        sent++;
      end else begin
        send_row(plain_row(rand_item(2'($urandom_range(0, 3)))));
      end
    end
    send_row(plain_row(rand_item(ACT_EOF)));
  endtask

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL subtitle_layer_alpha_compositor_top");
    $finish;
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
        n_hold++;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin
    req_row_t              rows[$];
    logic [COORD_BITS-1:0] fw, fh;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset, nothing seen yet
    rows.push_back(mk_row(mk_item(ACT_EOF, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'hff, '1), 1, 0, '0));
    // opaque white layer, full and zero coverage
    rows.push_back(mk_row(mk_item(ACT_HEADER, 0, 0, 2, 1, 32'hffffff00, 0, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'hff, 0), 1, 1,
                          mk_pix_res(0, 0, 32'hffffffff)));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'h00, 32'h12345678), 1, 1,
                          mk_pix_res(1, 0, 32'h12345678)));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'h80, 32'h80808080), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_EOF, 0, 0, 0, 0, 0, 0, 0), 1, 1,
                          mk_clip_res(0, 0, 2, 1)));
    rows.push_back(mk_row(mk_item(ACT_EOF, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_UNUSED, 5, 5, 5, 5, '1, '1, '1), 1, 0, '0));
    // largest layer: coordinates and box sums at their top
    rows.push_back(mk_row(mk_item(ACT_HEADER, 4095, 4095, 4095, 4095, 0, 0, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'hff, '1), 1, 1,
                          mk_pix_res(4095, 4095, 32'hff000000)));
    rows.push_back(plain_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'h5a, 32'h3c96c3a5)));
    rows.push_back(mk_row(mk_item(ACT_EOF, 0, 0, 0, 0, 0, 0, 0), 1, 1,
                          mk_clip_res(1920, 1080, 8190, 8190)));
    // zero width, then zero height: pixels dropped
    rows.push_back(mk_row(mk_item(ACT_HEADER, 7, 9, 0, 5, '1, 0, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'hff, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_HEADER, 3, 2, 3, 0, 32'ha0b0c0d0, 0, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'd200, '1), 1, 0, '0));
    rows.push_back(plain_row(mk_item(ACT_EOF, 0, 0, 0, 0, 0, 0, 0)));
    // layer keeps blending across end of frame
    rows.push_back(plain_row(mk_item(ACT_HEADER, 10, 20, 3, 2, 32'h11223380, 0, 0)));
    rows.push_back(plain_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'hff, 32'hff000000)));
    rows.push_back(plain_row(mk_item(ACT_EOF, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(plain_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'h40, 32'h00ffffff)));
    // fully transparent layer color leaves the old pixel
    rows.push_back(mk_row(mk_item(ACT_HEADER, 100, 50, 1, 2, 32'h445566ff, 0, 0), 1, 0, '0));
    rows.push_back(mk_row(mk_item(ACT_PIXEL, 0, 0, 0, 0, 0, 8'hff, 32'h89abcdef), 1, 1,
                          mk_pix_res(100, 50, 32'h89abcdef)));
    rows.push_back(plain_row(mk_item(ACT_EOF, 0, 0, 0, 0, 0, 0, 0)));

    foreach (rows[i]) send_row(rows[i]);
    wait_drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fw = '0; fh = '0; end
        1: begin fw = '1; fh = '1; end
        3: begin fw = FRAME_WIDTH_RST; fh = FRAME_HEIGHT_RST; end
        5: begin fw = '1; fh = '0; end
        default: begin fw = COORD_BITS'($urandom); fh = COORD_BITS'($urandom); end
      endcase
      write_frame_reg(REG_FRAME_WIDTH, fw);
      write_frame_reg(REG_FRAME_HEIGHT, fh);
      steady = (p == 2);
      if (p == 1) hold_out = 1'b1;
      run_random(PHASE_ITEMS);
      wait_drain();
    end

    $display("Covered %0d requests: %0d layer headers, %0d blended pixels, %0d clip boxes",
             n_req, n_headers, n_blended, n_boxes);
    $display("%0d register writes, %0d long output hold-offs, %0d failures",
             n_cfg, n_hold, n_fail);
    if (n_fail == 0) begin
      $display("PASS subtitle_layer_alpha_compositor_top");
    end else begin
      $display("FAIL subtitle_layer_alpha_compositor_top");
    end
    $finish;
  end

endmodule
